// ===== src/nems_pkg.sv =====
package nems_pkg;

    // default sizes of the table
    localparam int ENTRIES_DEF    = 64;
    localparam int NAME_BYTES_DEF = 128;

    // fixed field widths
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    // commands carried on the final byte
    localparam logic [1:0] CMD_QUERY  = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // result codes
    localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SETTLE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FINAL  = 5'b01000,
        S_SHIFT  = 5'b10000
    } t_state;

    // strobes broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic cmp_long;
        logic rd_en;
        logic fill_wr;
        logic shift_wr;
        logic scan_clr;
        logic scan_en;
        logic store_commit;
        logic remove_commit;
        logic clear_flags;
    } t_cell_ctl;

endpackage

// ===== src/nems_cell.sv =====
module nems_cell import nems_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF,
    parameter int IDX        = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_cell_ctl                           i_ctl,
    input  logic [7:0]                          i_cmp_byte,
    input  logic [$clog2(NAME_BYTES)-1:0]       i_cmp_pos,
    input  logic [$clog2(NAME_BYTES)-1:0]       i_rd_addr,
    input  logic [$clog2(NAME_BYTES)-1:0]       i_wr_addr,
    input  logic [7:0]                          i_fill_byte,
    input  logic [$clog2(ENTRIES+1)-1:0]        i_count,
    input  logic [$clog2(NAME_BYTES+1)-1:0]     i_in_len,
    input  logic [$clog2(NAME_BYTES)-1:0]       i_keep,
    input  logic                                i_seen,
    output logic                                o_seen,
    input  logic [7:0]                          i_next_rd,
    output logic [7:0]                          o_rd,
    input  logic [$clog2(NAME_BYTES)-1:0]       i_next_len,
    output logic [$clog2(NAME_BYTES)-1:0]       o_len
);

    localparam int AW = $clog2(NAME_BYTES);
    localparam int LW = $clog2(NAME_BYTES+1);
    localparam int CW = $clog2(ENTRIES+1);

    logic [7:0]    r_mem [NAME_BYTES];
    logic [7:0]    r_rd;
    logic [AW-1:0] r_len;
    logic          r_flag;
    logic          r_seen;
    logic          r_shift;
    logic          mem_we;
    logic [7:0]    mem_wdata;
    logic          is_tail;
    logic          hit;

    // this cell is the free slot at the end of the table
    assign is_tail = (CW'(IDX) == i_count);

    // name bytes go into the free slot, the removal sweep pulls from the neighbour
    assign mem_we    = (i_ctl.fill_wr && is_tail) || (i_ctl.shift_wr && r_shift);
    assign mem_wdata = i_ctl.fill_wr ? i_fill_byte : i_next_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_wr_addr] <= mem_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // full match of the finished name against a live entry
    assign hit    = r_flag && (LW'(r_len) == i_in_len) && (CW'(IDX) < i_count);
    assign o_seen = r_seen || hit;
    assign o_rd   = r_rd;
    assign o_len  = r_len;

    // match flag, earlier-hit chain and shift mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b1;
            r_seen  <= 1'b0;
            r_shift <= 1'b0;
        end else begin
            if (i_ctl.clear_flags) begin
                r_flag <= 1'b1;
            end else if (i_ctl.cmp_en) begin
                r_flag <= r_flag && !i_ctl.cmp_long && (i_cmp_pos < r_len)
                          && (r_rd == i_cmp_byte);
            end
            if (i_ctl.scan_clr) begin
                r_seen <= 1'b0;
            end else if (i_ctl.scan_en) begin
                r_seen <= i_seen;
            end
            if (i_ctl.remove_commit) begin
                r_shift <= o_seen;
            end
        end
    end

    // stored length: set on store, taken from the neighbour on removal
    always_ff @(posedge i_clk) begin
        if (i_ctl.store_commit && is_tail) begin
            r_len <= i_keep;
        end else if (i_ctl.remove_commit && o_seen) begin
            r_len <= i_next_len;
        end
    end

endmodule

// ===== src/nems_ctrl.sv =====
module nems_ctrl import nems_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_command,
    input  logic [7:0]                          i_name_byte,
    input  logic                                i_name_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [STATUS_W-1:0]                 o_status,
    output logic [TOTAL_W-1:0]                  o_entry_total,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [CFG_W-1:0]                    i_cfg_data,
    input  logic                                i_found,
    output t_cell_ctl                           o_ctl,
    output logic [7:0]                          o_cmp_byte,
    output logic [$clog2(NAME_BYTES)-1:0]       o_cmp_pos,
    output logic [$clog2(NAME_BYTES)-1:0]       o_rd_addr,
    output logic [$clog2(NAME_BYTES)-1:0]       o_wr_addr,
    output logic [$clog2(ENTRIES+1)-1:0]        o_count,
    output logic [$clog2(NAME_BYTES+1)-1:0]     o_in_len,
    output logic [$clog2(NAME_BYTES)-1:0]       o_keep
);

    localparam int AW   = $clog2(NAME_BYTES);
    localparam int LW   = $clog2(NAME_BYTES+1);
    localparam int CW   = $clog2(ENTRIES+1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    t_state              r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic [CW-1:0]       r_count, n_count;
    logic [CFG_W-1:0]    r_cap;
    logic [CW-1:0]       r_scan_cnt, n_scan_cnt;
    logic [LW-1:0]       r_shift_cnt, n_shift_cnt;
    logic                r_cmp_valid;
    logic                r_cmp_long;
    logic [7:0]          r_cmp_byte;
    logic [AW-1:0]       r_cmp_pos;
    logic [1:0]          r_cmd;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [TOTAL_W-1:0]  r_total;
    logic                load_out;
    logic                accept;
    logic                long_now;
    logic [AW-1:0]       p_addr;
    logic [LW-1:0]       shift_prev;
    logic [LW-1:0]       keep_full;
    logic                slot_free;
    logic                full;
    logic [CMPW-1:0]     total_x;
    t_cell_ctl           ctl;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign long_now   = (r_len >= LW'(NAME_BYTES - 1));
    assign p_addr     = long_now ? '0 : r_len[AW-1:0];
    assign shift_prev = r_shift_cnt - LW'(1);
    assign keep_full  = long_now ? LW'(NAME_BYTES - 1) : r_len;
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign full       = (r_count >= CW'(ENTRIES)) || (CMPW'(r_count) >= CMPW'(r_cap));
    assign total_x    = CMPW'(n_count);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_count     = r_count;
        n_scan_cnt  = r_scan_cnt;
        n_shift_cnt = r_shift_cnt;
        n_status    = r_status;
        load_out    = 1'b0;
        ctl         = '0;
        ctl.cmp_en   = r_cmp_valid;
        ctl.cmp_long = r_cmp_long;
        case (r_state)
            S_IDLE: begin
                ctl.rd_en   = accept;
                ctl.fill_wr = accept && !long_now;
                if (accept) begin
                    n_len = (r_len == LW'(NAME_BYTES)) ? r_len : r_len + LW'(1);
                    if (i_name_last) begin
                        n_state = S_SETTLE;
                    end
                end
            end
            S_SETTLE: begin
                ctl.scan_clr = 1'b1;
                n_scan_cnt   = '0;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                ctl.scan_en = 1'b1;
                n_scan_cnt  = r_scan_cnt + CW'(1);
                if (r_scan_cnt == CW'(ENTRIES - 1)) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (r_cmd == CMD_UNUSED) begin
                    ctl.clear_flags = 1'b1;
                    n_len           = '0;
                    n_state         = S_IDLE;
                end else if (slot_free) begin
                    ctl.clear_flags = 1'b1;
                    n_len           = '0;
                    load_out        = 1'b1;
                    n_state         = S_IDLE;
                    case (r_cmd)
                        CMD_QUERY: begin
                            n_status = i_found ? ST_PRESENT : ST_ABSENT;
                        end
                        CMD_STORE: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (i_found) begin
                                n_status = ST_DUPLICATE;
                            end else begin
                                n_status         = ST_STORED;
                                ctl.store_commit = 1'b1;
                                n_count          = r_count + CW'(1);
                            end
                        end
                        default: begin
                            if (i_found) begin
                                n_status          = ST_REMOVED;
                                ctl.remove_commit = 1'b1;
                                n_count           = r_count - CW'(1);
                                n_shift_cnt       = '0;
                                n_state           = S_SHIFT;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                ctl.rd_en    = (r_shift_cnt < LW'(NAME_BYTES));
                ctl.shift_wr = (r_shift_cnt != '0);
                n_shift_cnt  = r_shift_cnt + LW'(1);
                if (r_shift_cnt == LW'(NAME_BYTES)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output slot: a taken result frees it, a new one fills it
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_scan_cnt  <= '0;
            r_shift_cnt <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_count     <= n_count;
            r_scan_cnt  <= n_scan_cnt;
            r_shift_cnt <= n_shift_cnt;
            r_cmp_valid <= accept;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmp_byte <= i_name_byte;
            r_cmp_long <= long_now;
            r_cmp_pos  <= r_len[AW-1:0];
            if (i_name_last) begin
                r_cmd <= i_command;
            end
        end
        if (load_out) begin
            r_status <= n_status;
            r_total  <= total_x[TOTAL_W-1:0];
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_total = r_total;
    assign o_cfg_ready   = 1'b1;
    assign o_ctl         = ctl;
    assign o_cmp_byte    = r_cmp_byte;
    assign o_cmp_pos     = r_cmp_pos;
    assign o_rd_addr     = (r_state == S_SHIFT) ? r_shift_cnt[AW-1:0] : p_addr;
    assign o_wr_addr     = (r_state == S_SHIFT) ? shift_prev[AW-1:0] : p_addr;
    assign o_count       = r_count;
    assign o_in_len      = r_len;
    assign o_keep        = keep_full[AW-1:0];

    // checks
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINAL))
        else $error("result appeared outside the final step");

    a_count_at_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state == S_FINAL))
        else $error("entry count moved outside the final step");

    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && slot_free && r_cmd == CMD_STORE && !full && !i_found)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("store did not append an entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count above table size");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(NAME_BYTES))
        else $error("incoming length past saturation");

endmodule

// ===== src/name_exact_match_store_top.sv =====
// channel | direction | handshake               | payload
// in      | request   | i_in_valid / o_in_stall  | i_command, i_name_byte, i_name_last
// out     | result    | o_out_valid / i_out_stall| o_status, o_entry_total
// cfg     | write     | i_cfg_valid / o_cfg_ready| i_cfg_data (capacity)
//
// a name byte that is not the last is taken back to back
// after the last byte: settle (last compare, scan clear), the earlier-hit ripple
// along the cell chain, then the final step (held while the result slot is full)
// a remove that hits adds the byte sweep through each cell memory
// reset clears the count, flags and sequencer state; entry memories are not swept
// a result waiting on a stalled output does not block the bytes of the next name
module name_exact_match_store_top import nems_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int NAME_BYTES = NAME_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_command,
    input  logic [7:0]          i_name_byte,
    input  logic                i_name_last,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [TOTAL_W-1:0]  o_entry_total,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(NAME_BYTES);
    localparam int LW = $clog2(NAME_BYTES+1);
    localparam int CW = $clog2(ENTRIES+1);

    t_cell_ctl     ctl;
    logic [7:0]    cmp_byte;
    logic [AW-1:0] cmp_pos;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] count;
    logic [LW-1:0] in_len;
    logic [AW-1:0] keep;
    logic          seen_w [ENTRIES+1];
    logic [7:0]    rd_w   [ENTRIES+1];
    logic [AW-1:0] len_w  [ENTRIES+1];

    // sequencer
    nems_ctrl #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_name_byte   (i_name_byte),
        .i_name_last   (i_name_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_total (o_entry_total),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_found       (seen_w[ENTRIES]),
        .o_ctl         (ctl),
        .o_cmp_byte    (cmp_byte),
        .o_cmp_pos     (cmp_pos),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_count       (count),
        .o_in_len      (in_len),
        .o_keep        (keep)
    );

    // chain ends
    assign seen_w[0]     = 1'b0;
    assign rd_w[ENTRIES]  = '0;
    assign len_w[ENTRIES] = '0;

    // one cell per entry
    for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
        nems_cell #(
            .ENTRIES    (ENTRIES),
            .NAME_BYTES (NAME_BYTES),
            .IDX        (e)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_cmp_byte  (cmp_byte),
            .i_cmp_pos   (cmp_pos),
            .i_rd_addr   (rd_addr),
            .i_wr_addr   (wr_addr),
            .i_fill_byte (i_name_byte),
            .i_count     (count),
            .i_in_len    (in_len),
            .i_keep      (keep),
            .i_seen      (seen_w[e]),
            .o_seen      (seen_w[e+1]),
            .i_next_rd   (rd_w[e+1]),
            .o_rd        (rd_w[e]),
            .i_next_len  (len_w[e+1]),
            .o_len       (len_w[e])
        );
    end

endmodule
